[sv/tce_pkg.sv]
`default_nettype none

package tce_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned STEP_W = 3;

  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_G     = 8'h47;
  localparam logic [BYTE_W-1:0] CH_F     = 8'h46;
  localparam logic [BYTE_W-1:0] CH_B     = 8'h42;
  localparam logic [BYTE_W-1:0] CH_J     = 8'h4A;
  localparam logic [BYTE_W-1:0] CH_I     = 8'h49;
  localparam logic [BYTE_W-1:0] ATTR_BLINK = 8'h80;

  localparam logic [MODE_W-1:0] MODE_BASE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ESC   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GLYPH = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FG    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BG    = 3'd4;

  // microcode step addresses
  localparam logic [STEP_W-1:0] STEP_FETCH = 3'd0;
  localparam logic [STEP_W-1:0] STEP_RCLR  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_JCLR  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_SCRL  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SCRG  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_GLYW  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_RDA   = 3'd6;
  localparam logic [STEP_W-1:0] STEP_RESP  = 3'd7;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_DISPATCH,
    COND_WALK,
    COND_OUT
  } cond_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_GLYPH,
    ACT_GLYPH_SCROLL,
    ACT_SCROLL,
    ACT_CLEAR,
    ACT_READ
  } act_e;

  typedef struct packed {
    logic              ready;
    logic              we;
    logic              wglyph;
    logic              whole;
    logic              rd;
    logic              resp;
    cond_e             cond;
    logic [STEP_W-1:0] next;
  } cw_t;

  function automatic cw_t ucode(input logic [STEP_W-1:0] step);
    cw_t cw;
    cw = '{ready: 1'b0, we: 1'b0, wglyph: 1'b0, whole: 1'b0, rd: 1'b0, resp: 1'b0,
           cond: COND_NEXT, next: STEP_FETCH};
    case (step)
      STEP_FETCH: begin
        cw.ready = 1'b1;
        cw.cond  = COND_DISPATCH;
      end
      STEP_RCLR: begin
        cw.we    = 1'b1;
        cw.whole = 1'b1;
        cw.cond  = COND_WALK;
        cw.next  = STEP_FETCH;
      end
      STEP_JCLR: begin
        cw.we    = 1'b1;
        cw.whole = 1'b1;
        cw.cond  = COND_WALK;
        cw.next  = STEP_RESP;
      end
      STEP_SCRL: begin
        cw.we   = 1'b1;
        cw.cond = COND_WALK;
        cw.next = STEP_RESP;
      end
      STEP_SCRG: begin
        cw.we   = 1'b1;
        cw.cond = COND_WALK;
        cw.next = STEP_GLYW;
      end
      STEP_GLYW: begin
        cw.we     = 1'b1;
        cw.wglyph = 1'b1;
        cw.next   = STEP_RESP;
      end
      STEP_RDA: begin
        cw.rd   = 1'b1;
        cw.next = STEP_RESP;
      end
      STEP_RESP: begin
        cw.resp = 1'b1;
        cw.cond = COND_OUT;
        cw.next = STEP_FETCH;
      end
      default: begin
        cw.next = STEP_FETCH;
      end
    endcase
    return cw;
  endfunction

  function automatic logic [STEP_W-1:0] dispatch(input act_e act);
    logic [STEP_W-1:0] step;
    case (act)
      ACT_GLYPH:        step = STEP_GLYW;
      ACT_GLYPH_SCROLL: step = STEP_SCRG;
      ACT_SCROLL:       step = STEP_SCRL;
      ACT_CLEAR:        step = STEP_JCLR;
      ACT_READ:         step = STEP_RDA;
      default:          step = STEP_RESP;
    endcase
    return step;
  endfunction

  function automatic logic [3:0] hex_digit(input logic [BYTE_W-1:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      d = c[3:0] + 4'd9;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

[sv/tce_req_if.sv]
`default_nettype none

interface tce_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [tce_pkg::BYTE_W-1:0]   data_byte;
  logic [tce_pkg::ROW_W-1:0]    read_row;
  logic [tce_pkg::COL_W-1:0]    read_col;

  modport source (output valid, req_type, data_byte, read_row, read_col, input ready);
  modport sink (input valid, req_type, data_byte, read_row, read_col, output ready);
endinterface

`default_nettype wire

[sv/tce_rsp_if.sv]
`default_nettype none

interface tce_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [tce_pkg::CELL_W-1:0]   cell_entry;
  logic [tce_pkg::COL_W-1:0]    cursor_column;
  logic [tce_pkg::BYTE_W-1:0]   attribute;
  logic [tce_pkg::MODE_W-1:0]   parse_mode;

  modport source (output valid, cell_entry, cursor_column, attribute, parse_mode,
                  input ready);
  modport sink (input valid, cell_entry, cursor_column, attribute, parse_mode,
                output ready);
endinterface

`default_nettype wire

[sv/tce_ram.sv]
`default_nettype none

module tce_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic                     we_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/text_console_escape_engine.sv]
// text console with escape parser over a row-rotating screen store
// req_i carries one transaction per request: a byte feed (req_type 0) or a
// cell read (req_type 1); rsp_o returns exactly one transaction per request
// with the cell read (0 on a feed), cursor column, attribute and parse mode
// a request is taken only in the fetch step of the microcode sequencer, so
// one request is in work at a time; steps from acceptance to rsp_o.valid:
//   plain feed (mode change, colour, backspace): response step only
//   glyph or cell read: store write or store read, then response step
//   line feed: bottom-row walk; glyph that wraps: bottom-row walk, glyph write
//   clear screen: walk of every cell; each of these ends in the response step
// the walks run over the single write port of the screen store, which the
// sequencer walks one cell per cycle; scrolling rotates a top-row pointer
// and clears only the new bottom row
// after reset the sequencer clears all SCREEN_ROWS * SCREEN_COLUMNS cells
// (2000 by default) of the store with req_i.ready low
// rsp_o has an output register: a stalled receiver holds the result there
// while the next request is taken; its result waits until the slot frees
`default_nettype none

module text_console_escape_engine #(
  parameter int unsigned SCREEN_COLUMNS = 80,
  parameter int unsigned SCREEN_ROWS    = 25
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tce_req_if.sink    req_i,
  tce_rsp_if.source  rsp_o
);

  localparam int unsigned CELLS = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(SCREEN_ROWS);
  localparam int unsigned SW    = ((RW > tce_pkg::ROW_W) ? RW : tce_pkg::ROW_W) + 1;
  localparam int unsigned CW    = tce_pkg::COL_W;
  localparam int unsigned BW    = tce_pkg::BYTE_W;

  localparam logic [RW-1:0] LAST_ROW = RW'(SCREEN_ROWS - 1);
  localparam logic [SW-1:0] NROWS_S  = SW'(SCREEN_ROWS);
  localparam logic [CW-1:0] NCOLS    = CW'(SCREEN_COLUMNS);
  localparam logic [CW-1:0] LAST_COL = CW'(SCREEN_COLUMNS - 1);
  localparam logic [AW-1:0] NCOLS_A  = AW'(SCREEN_COLUMNS);
  localparam logic [AW-1:0] CELLS_A  = AW'(CELLS - 1);

  logic [tce_pkg::STEP_W-1:0] pc_q, pc_d;
  logic [RW-1:0]              row_q, row_d;
  logic [CW-1:0]              col_q, col_d;
  logic [RW-1:0]              top_q, top_d;
  logic [CW-1:0]              cur_q, cur_d;
  logic [BW-1:0]              attr_q, attr_d;
  logic [tce_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [BW-1:0]              glyph_q;
  logic                       rd_q;
  logic                       oor_q;
  logic                       ovalid_q, ovalid_d;
  logic [tce_pkg::CELL_W-1:0] ocell_q;
  logic [CW-1:0]              ocur_q;
  logic [BW-1:0]              oattr_q;
  logic [tce_pkg::MODE_W-1:0] omode_q;

  tce_pkg::cw_t  cw;
  tce_pkg::act_e act;
  logic          accept;
  logic          walk_end;
  logic          out_free;
  logic          put;
  logic [3:0]    dig;
  logic [BW-1:0] byte_in;
  logic [RW-1:0] bottom_row;
  logic [RW-1:0] top_next;
  logic [SW-1:0] rsum;
  logic [SW-1:0] rphys;
  logic          oor;
  logic [CW-1:0]              cur_n;
  logic [BW-1:0]              attr_n;
  logic [tce_pkg::MODE_W-1:0] mode_n;
  logic [AW-1:0]              mem_addr;
  logic [tce_pkg::CELL_W-1:0] mem_wdata;
  logic [tce_pkg::CELL_W-1:0] mem_rdata;

  assign cw       = tce_pkg::ucode(pc_q);
  assign accept   = req_i.valid && cw.ready;
  assign out_free = !ovalid_q || rsp_o.ready;
  assign walk_end = (col_q == LAST_COL) && (!cw.whole || (row_q == LAST_ROW));
  assign byte_in  = req_i.data_byte;
  assign dig      = tce_pkg::hex_digit(byte_in);

  assign bottom_row = (top_q == '0) ? LAST_ROW : top_q - 1'b1;
  assign top_next   = (top_q == LAST_ROW) ? '0 : top_q + 1'b1;
  assign rsum       = SW'(req_i.read_row) + SW'(top_q);
  assign rphys      = (rsum >= NROWS_S) ? rsum - NROWS_S : rsum;
  assign oor        = (SW'(req_i.read_row) >= NROWS_S) || (req_i.read_col >= NCOLS);

  // request decode
  always_comb begin
    act    = tce_pkg::ACT_NONE;
    mode_n = mode_q;
    attr_n = attr_q;
    cur_n  = cur_q;
    put    = 1'b0;
    if (req_i.req_type) begin
      act = tce_pkg::ACT_READ;
    end else begin
      case (mode_q)
        tce_pkg::MODE_BASE: begin
          if (byte_in == tce_pkg::CH_ESC) begin
            mode_n = tce_pkg::MODE_ESC;
          end else if (byte_in == tce_pkg::CH_BS) begin
            if (cur_q != '0) begin
              cur_n = cur_q - 1'b1;
            end
          end else if (byte_in == tce_pkg::CH_LF) begin
            act   = tce_pkg::ACT_SCROLL;
            cur_n = '0;
          end else if (byte_in >= tce_pkg::CH_SPACE && byte_in != tce_pkg::CH_DEL) begin
            put = 1'b1;
          end
        end
        tce_pkg::MODE_ESC: begin
          mode_n = tce_pkg::MODE_BASE;
          if (byte_in == tce_pkg::CH_G) begin
            mode_n = tce_pkg::MODE_GLYPH;
          end else if (byte_in == tce_pkg::CH_F) begin
            mode_n = tce_pkg::MODE_FG;
          end else if (byte_in == tce_pkg::CH_B) begin
            mode_n = tce_pkg::MODE_BG;
          end else if (byte_in == tce_pkg::CH_J) begin
            act   = tce_pkg::ACT_CLEAR;
            cur_n = '0;
          end else if (byte_in == tce_pkg::CH_I) begin
            attr_n = attr_q ^ tce_pkg::ATTR_BLINK;
          end
        end
        tce_pkg::MODE_GLYPH: begin
          put    = 1'b1;
          mode_n = tce_pkg::MODE_BASE;
        end
        tce_pkg::MODE_FG: begin
          attr_n = {1'b0, attr_q[6:4], dig};
          mode_n = tce_pkg::MODE_BASE;
        end
        default: begin
          attr_n = {1'b0, dig[2:0], attr_q[3:0]};
          mode_n = tce_pkg::MODE_BASE;
        end
      endcase
      if (put) begin
        if (cur_q >= NCOLS) begin
          act   = tce_pkg::ACT_GLYPH_SCROLL;
          cur_n = CW'(1);
        end else begin
          act   = tce_pkg::ACT_GLYPH;
          cur_n = cur_q + 1'b1;
        end
      end
    end
  end

  // sequencer and walk counters
  always_comb begin
    pc_d   = pc_q;
    row_d  = row_q;
    col_d  = col_q;
    top_d  = top_q;
    cur_d  = cur_q;
    attr_d = attr_q;
    mode_d = mode_q;
    case (cw.cond)
      tce_pkg::COND_DISPATCH: begin
        if (accept) begin
          pc_d   = tce_pkg::dispatch(act);
          cur_d  = cur_n;
          attr_d = attr_n;
          mode_d = mode_n;
          case (act)
            tce_pkg::ACT_READ: begin
              row_d = rphys[RW-1:0];
              col_d = req_i.read_col;
            end
            tce_pkg::ACT_GLYPH: begin
              row_d = bottom_row;
              col_d = cur_q;
            end
            tce_pkg::ACT_GLYPH_SCROLL, tce_pkg::ACT_SCROLL: begin
              row_d = top_q;
              col_d = '0;
              top_d = top_next;
            end
            tce_pkg::ACT_CLEAR: begin
              row_d = '0;
              col_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      tce_pkg::COND_WALK: begin
        if (col_q == LAST_COL) begin
          col_d = '0;
          if (cw.whole) begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
        if (walk_end) begin
          pc_d = cw.next;
        end
      end
      tce_pkg::COND_OUT: begin
        if (out_free) begin
          pc_d = cw.next;
        end
      end
      default: begin
        pc_d = cw.next;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= tce_pkg::STEP_RCLR;
      row_q  <= '0;
      col_q  <= '0;
      top_q  <= '0;
      cur_q  <= '0;
      attr_q <= '0;
      mode_q <= tce_pkg::MODE_BASE;
    end else begin
      pc_q   <= pc_d;
      row_q  <= row_d;
      col_q  <= col_d;
      top_q  <= top_d;
      cur_q  <= cur_d;
      attr_q <= attr_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      glyph_q <= byte_in;
      rd_q    <= req_i.req_type;
      oor_q   <= oor;
    end
  end

  // screen store
  assign mem_addr  = AW'(row_q) * NCOLS_A + AW'(col_q);
  assign mem_wdata = {attr_q, cw.wglyph ? glyph_q : BW'(0)};

  tce_ram #(
    .WIDTH (tce_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .addr_i  (mem_addr),
    .we_i    (cw.we),
    .wdata_i (mem_wdata),
    .re_i    (cw.rd),
    .rdata_o (mem_rdata)
  );

  // output register
  always_comb begin
    ovalid_d = ovalid_q;
    if (cw.resp && out_free) begin
      ovalid_d = 1'b1;
    end else if (rsp_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw.resp && out_free) begin
      ocell_q <= (rd_q && !oor_q) ? mem_rdata : '0;
      ocur_q  <= cur_q;
      oattr_q <= attr_q;
      omode_q <= mode_q;
    end
  end

  assign req_i.ready         = cw.ready;
  assign rsp_o.valid         = ovalid_q;
  assign rsp_o.cell_entry    = ocell_q;
  assign rsp_o.cursor_column = ocur_q;
  assign rsp_o.attribute     = oattr_q;
  assign rsp_o.parse_mode    = omode_q;

`ifndef SYNTHESIS
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cw.we |-> mem_addr <= CELLS_A)
    else $error("screen write outside the store");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= NCOLS)
    else $error("cursor beyond screen width");

  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= LAST_ROW)
    else $error("top row pointer out of range");

  a_read_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.req_type) |=> pc_q == tce_pkg::STEP_RDA)
    else $error("read request did not start a store read");

  a_resp_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == tce_pkg::STEP_RDA) |=> pc_q == tce_pkg::STEP_RESP)
    else $error("store read not followed by response step");
`endif

endmodule

`default_nettype wire

[tb/text_console_escape_engine_tb.sv]
`timescale 1ns / 100ps

module text_console_escape_engine_tb;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int BOTTOM = COLS * (ROWS - 1);
  localparam int RANDOM_ITEMS = 880;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 250;
  localparam int CALM_ITEMS   = 100;
  localparam int DIR_N        = 27;

  localparam logic REQ_FEED = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic [tce_pkg::CELL_W-1:0] entry;
    logic [tce_pkg::COL_W-1:0]  column;
    logic [tce_pkg::BYTE_W-1:0] attr;
    logic [tce_pkg::MODE_W-1:0] mode;
  } console_view_t;

  typedef struct packed {
    logic                       is_read;
    logic [tce_pkg::BYTE_W-1:0] data;
    logic [tce_pkg::ROW_W-1:0]  row;
    logic [tce_pkg::COL_W-1:0]  col;
    logic                       fixed;
    console_view_t              want;
  } console_req_t;

  logic clk_i;
  logic rst_ni;

  tce_req_if req_bus ();
  tce_rsp_if rsp_bus ();

  text_console_escape_engine #(
    .SCREEN_COLUMNS(COLS),
    .SCREEN_ROWS   (ROWS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  // predicted console state
  logic [tce_pkg::CELL_W-1:0] screen_q [CELLS];
  logic [tce_pkg::COL_W-1:0]  cur_col;
  logic [tce_pkg::BYTE_W-1:0] cur_attr;
  logic [tce_pkg::MODE_W-1:0] cur_mode;

  console_req_t  stim_q [$];
  console_view_t pending_views [$];

  int  n_accepted;
  int  n_results;
  int  n_errors;
  int  n_reads;
  int  n_wraps;
  int  n_clears;
  int  n_scrolls;
  int  cycles;
  int  cycle_limit = 100_000_000;
  bit  calm;

  // directed opening: reset contents, field extremes, each escape command
  console_req_t opening_rows [DIR_N] = '{
    '{REQ_READ, 8'h00, 5'd0,  7'd0,   1'b1, '{16'h0000, 7'd0, 8'h00, tce_pkg::MODE_BASE}},
    '{REQ_READ, 8'h00, 5'd24, 7'd79,  1'b1, '{16'h0000, 7'd0, 8'h00, tce_pkg::MODE_BASE}},
    '{REQ_READ, 8'hFF, 5'd31, 7'd127, 1'b1, '{16'h0000, 7'd0, 8'h00, tce_pkg::MODE_BASE}},
    '{REQ_FEED, 8'h41, 5'd0,  7'd0,   1'b1, '{16'h0000, 7'd1, 8'h00, tce_pkg::MODE_BASE}},
    '{REQ_FEED, 8'hFF, 5'd31, 7'd127, 1'b0, '0},
    '{REQ_FEED, tce_pkg::CH_DEL, 5'd0, 7'd0, 1'b0, '0},
    '{REQ_FEED, 8'h00,  5'd0, 7'd0,   1'b0, '0},
    '{REQ_FEED, tce_pkg::CH_BS,  5'd0, 7'd0, 1'b0, '0},
    '{REQ_FEED, tce_pkg::CH_ESC, 5'd0, 7'd0, 1'b0, '0},
    '{REQ_FEED, tce_pkg::CH_F,   5'd0, 7'd0, 1'b0, '0},
    '{REQ_FEED, 8'h66,  5'd0, 7'd0,   1'b0, '0},
    '{REQ_FEED, tce_pkg::CH_ESC, 5'd0, 7'd0, 1'b0, '0},
    '{REQ_FEED, tce_pkg::CH_B,   5'd0, 7'd0, 1'b0, '0},
    '{REQ_FEED, 8'h37,  5'd0, 7'd0,   1'b0, '0},
    '{REQ_FEED, tce_pkg::CH_ESC, 5'd0, 7'd0, 1'b0, '0},
    '{REQ_FEED, tce_pkg::CH_I,   5'd0, 7'd0, 1'b0, '0},
    '{REQ_FEED, tce_pkg::CH_ESC, 5'd0, 7'd0, 1'b0, '0},
    '{REQ_FEED, tce_pkg::CH_F,   5'd0, 7'd0, 1'b0, '0},
    '{REQ_FEED, 8'h7A,  5'd0, 7'd0,   1'b0, '0},
    '{REQ_FEED, tce_pkg::CH_ESC, 5'd0, 7'd0, 1'b0, '0},
    '{REQ_FEED, tce_pkg::CH_G,   5'd0, 7'd0, 1'b0, '0},
    '{REQ_FEED, 8'h00,  5'd0, 7'd0,   1'b0, '0},
    '{REQ_READ, 8'h00, 5'd24, 7'd1,   1'b0, '0},
    '{REQ_FEED, tce_pkg::CH_LF,  5'd0, 7'd0, 1'b0, '0},
    '{REQ_FEED, tce_pkg::CH_ESC, 5'd0, 7'd0, 1'b0, '0},
    '{REQ_FEED, tce_pkg::CH_J,   5'd0, 7'd0, 1'b0, '0},
    '{REQ_READ, 8'h00, 5'd24, 7'd0,   1'b0, '0}
  };

  function automatic void scroll_screen();
    for (int i = 0; i < BOTTOM; i++) screen_q[i] = screen_q[i + COLS];
    for (int i = 0; i < COLS; i++) screen_q[BOTTOM + i] = {cur_attr, 8'h00};
    cur_col = '0;
    n_scrolls++;
  endfunction

  function automatic void place_glyph(input logic [tce_pkg::BYTE_W-1:0] g);
    if (cur_col >= COLS) begin
      scroll_screen();
      n_wraps++;
    end
    screen_q[BOTTOM + cur_col] = {cur_attr, g};
    cur_col = cur_col + 1'b1;
  endfunction

  function automatic logic [3:0] colour_digit(input logic [tce_pkg::BYTE_W-1:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= "0" && c <= "9") d = 4'(c - "0");
    else if (c >= "a" && c <= "f") d = 4'(c - "a" + 10);
    else if (c >= "A" && c <= "F") d = 4'(c - "A" + 10);
    return d;
  endfunction

  function automatic console_view_t console_step(input console_req_t r);
    console_view_t v;
    logic [3:0]    dig;
    v.entry = '0;
    dig = colour_digit(r.data);
    if (r.is_read == REQ_READ) begin
      n_reads++;
      if (r.row < ROWS && r.col < COLS) v.entry = screen_q[r.row * COLS + r.col];
    end else begin
      case (cur_mode)
        tce_pkg::MODE_BASE: begin
          if (r.data == tce_pkg::CH_ESC) cur_mode = tce_pkg::MODE_ESC;
          else if (r.data == tce_pkg::CH_BS) begin
            if (cur_col != 0) cur_col = cur_col - 1'b1;
          end else if (r.data == tce_pkg::CH_LF) scroll_screen();
          else if (r.data >= tce_pkg::CH_SPACE && r.data != tce_pkg::CH_DEL)
            place_glyph(r.data);
        end
        tce_pkg::MODE_ESC: begin
          cur_mode = tce_pkg::MODE_BASE;
          if (r.data == tce_pkg::CH_G) cur_mode = tce_pkg::MODE_GLYPH;
          else if (r.data == tce_pkg::CH_F) cur_mode = tce_pkg::MODE_FG;
          else if (r.data == tce_pkg::CH_B) cur_mode = tce_pkg::MODE_BG;
          else if (r.data == tce_pkg::CH_J) begin
            for (int i = 0; i < CELLS; i++) screen_q[i] = {cur_attr, 8'h00};
            cur_col = '0;
            n_clears++;
          end else if (r.data == tce_pkg::CH_I) cur_attr = cur_attr ^ tce_pkg::ATTR_BLINK;
        end
        tce_pkg::MODE_GLYPH: begin
          place_glyph(r.data);
          cur_mode = tce_pkg::MODE_BASE;
        end
        tce_pkg::MODE_FG: begin
          cur_attr = {1'b0, cur_attr[6:4], dig};
          cur_mode = tce_pkg::MODE_BASE;
        end
        default: begin
          cur_attr = {1'b0, dig[2:0], cur_attr[3:0]};
          cur_mode = tce_pkg::MODE_BASE;
        end
      endcase
    end
    v.column = cur_col;
    v.attr   = cur_attr;
    v.mode   = cur_mode;
    return v;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic void push_feed(input logic [tce_pkg::BYTE_W-1:0] b);
    stim_q.push_back('{REQ_FEED, b, tce_pkg::ROW_W'($urandom), tce_pkg::COL_W'($urandom),
                       1'b0, '0});
  endfunction

  function automatic void push_read(input int r, input int c);
    stim_q.push_back('{REQ_READ, tce_pkg::BYTE_W'($urandom), tce_pkg::ROW_W'(r),
                       tce_pkg::COL_W'(c), 1'b0, '0});
  endfunction

  function automatic logic [tce_pkg::BYTE_W-1:0] any_digit_char();
    string hexchars;
    hexchars = "0123456789abcdefABCDEF";
    if ($urandom_range(0, 5) == 0) return tce_pkg::BYTE_W'($urandom);
    return hexchars[$urandom_range(0, 21)];
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    for (int i = 0; i < CELLS; i++) screen_q[i] = '0;
    cur_col  = '0;
    cur_attr = '0;
    cur_mode = tce_pkg::MODE_BASE;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > cycle_limit) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycles, pending_views.size());
      $display("Verification failed");
      $finish;
    end
  end

  // compare results and predict accepted transactions
  always @(posedge clk_i) begin : scoreboard
    console_view_t got;
    console_view_t want;
    console_view_t predicted;
    console_req_t  r;
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        got = '{rsp_bus.cell_entry, rsp_bus.cursor_column, rsp_bus.attribute,
                rsp_bus.parse_mode};
        n_results++;
        if (pending_views.size() == 0) begin
          flag_error($sformatf("transaction with nothing expected: %h", got));
        end else begin
          want = pending_views.pop_front();
          if (got.entry !== want.entry)
            flag_error($sformatf("result %0d cell_entry %h, want %h", n_results, got.entry,
                                 want.entry));
          if (got.column !== want.column)
            flag_error($sformatf("result %0d cursor_column %0d, want %0d", n_results,
                                 got.column, want.column));
          if (got.attr !== want.attr)
            flag_error($sformatf("result %0d attribute %h, want %h", n_results, got.attr,
                                 want.attr));
          if (got.mode !== want.mode)
            flag_error($sformatf("result %0d parse_mode %0d, want %0d", n_results, got.mode,
                                 want.mode));
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        r = stim_q[n_accepted];
        predicted = console_step(r);
        pending_views.push_back(r.fixed ? r.want : predicted);
        n_accepted++;
      end
    end
  end

  // receiver: random stalls, one long hold-off, none in the tail
  initial begin : receiver
    bit held;
    held = 1'b0;
    rsp_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && n_accepted >= HOLD_AFTER) begin
        held = 1'b1;
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        rsp_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  // sender
  initial begin : sender
    int n_rand;
    int pick;
    int burst;
    int pause_at;
    int calm_at;
    int n_j;
    req_bus.valid     <= 1'b0;
    req_bus.req_type  <= REQ_FEED;
    req_bus.data_byte <= '0;
    req_bus.read_row  <= '0;
    req_bus.read_col  <= '0;
    calm = 1'b0;

    foreach (opening_rows[i]) stim_q.push_back(opening_rows[i]);
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if ($urandom_range(0, 9) < 5) push_read(24, $urandom_range(0, COLS - 1));
        else if ($urandom_range(0, 9) < 6)
          push_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
        else push_read($urandom_range(0, 31), $urandom_range(0, 127));
        n_rand++;
      end else if (pick < 70) begin
        push_feed(tce_pkg::BYTE_W'($urandom_range(8'h20, 8'hFF)));
        n_rand++;
      end else if (pick < 74) begin
        burst = $urandom_range(20, 90);
        for (int k = 0; k < burst; k++) begin
          if ($urandom_range(0, 7) == 0) push_read(24, $urandom_range(0, COLS - 1));
          else push_feed(tce_pkg::BYTE_W'($urandom_range(8'h20, 8'hFF)));
        end
        n_rand += burst;
      end else if (pick < 78) begin
        push_feed(tce_pkg::CH_LF);
        n_rand++;
      end else if (pick < 82) begin
        push_feed(tce_pkg::CH_BS);
        n_rand++;
      end else if (pick < 95) begin
        push_feed(tce_pkg::CH_ESC);
        case ($urandom_range(0, 15))
          0, 1, 2: begin
            push_feed(tce_pkg::CH_G);
            push_feed(tce_pkg::BYTE_W'($urandom));
          end
          3, 4, 5: begin
            push_feed(tce_pkg::CH_F);
            push_feed(any_digit_char());
          end
          6, 7, 8: begin
            push_feed(tce_pkg::CH_B);
            push_feed(any_digit_char());
          end
          9, 10:   push_feed(tce_pkg::CH_I);
          11:      push_feed(tce_pkg::CH_J);
          default: push_feed(tce_pkg::BYTE_W'($urandom));
        endcase
        n_rand += 3;
      end else begin
        push_feed(tce_pkg::BYTE_W'($urandom));
        n_rand++;
      end
    end

    n_j = 0;
    foreach (stim_q[i])
      if (stim_q[i].is_read == REQ_FEED && stim_q[i].data == tce_pkg::CH_J) n_j++;
    cycle_limit = 4 * (CELLS + HOLD_CYCLES + stim_q.size() * (COLS + 3 + 36) +
                       n_j * (CELLS + 2));
    pause_at = stim_q.size() / 2;
    calm_at  = stim_q.size() - CALM_ITEMS;

    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    for (int i = 0; i < stim_q.size(); i++) begin
      calm = (i >= calm_at);
      if (i == pause_at) begin
        req_bus.valid <= 1'b0;
        do @(negedge clk_i); while (pending_views.size() != 0);
        @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        req_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= stim_q[i].is_read;
      req_bus.data_byte <= stim_q[i].data;
      req_bus.read_row  <= stim_q[i].row;
      req_bus.read_col  <= stim_q[i].col;
      do @(posedge clk_i); while (!req_bus.ready);
    end
    req_bus.valid <= 1'b0;

    do @(negedge clk_i); while (pending_views.size() != 0);
    repeat (CELLS + 4) @(posedge clk_i);

    $display("%0d transactions: %0d cell reads, %0d scrolls, %0d line wraps, %0d clears",
             n_accepted, n_reads, n_scrolls, n_wraps, n_clears);
    $display("%0d results checked, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
